// ===== rtl/core/wildcard_abc_subsequence_counter_core_assert.svh =====
// Assertion macros used by the checker of the subsequence counter.
`ifndef WILDCARD_ABC_SUBSEQUENCE_COUNTER_CORE_ASSERT_SVH
`define WILDCARD_ABC_SUBSEQUENCE_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WASC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WASC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/wasc_pkg.sv =====
// Constants and types shared by the subsequence counter modules.
package wasc_pkg;

    localparam int unsigned C_CNT_W = 30;
    localparam int unsigned C_NUM_CELLS = 4;
    localparam logic [C_CNT_W-1:0] C_PRIME = 30'd1000000007;
    localparam logic [7:0] C_WILDCARD = 8'h3F;
    localparam logic [7:0] C_FIRST_LETTER = 8'h61;

    typedef struct packed {
        logic step;
        logic wild;
        logic match;
        logic restart;
        logic origin;
    } t_cell_ctrl;

endpackage

// ===== rtl/core/wasc_if.sv =====
// Handshake channels for the character words and the total words.
interface wasc_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink (input valid, input symbol, input last, output ready);
endinterface

interface wasc_total_if;
    logic        valid;
    logic        ready;
    logic [29:0] total;

    modport source (output valid, output total, input ready);
    modport sink (input valid, input total, output ready);
endinterface

// ===== rtl/core/wasc_cell.sv =====
// One cell of the count chain: weighted count of one pattern prefix, modulo the prime.
module wasc_cell
    import wasc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctrl         i_ctrl,
    input  logic [C_CNT_W-1:0] i_left,
    output logic [C_CNT_W-1:0] o_count,
    output logic [C_CNT_W-1:0] o_next
);

    localparam int unsigned SUM_W = C_CNT_W + 2;
    localparam logic [SUM_W-1:0] P1 = {2'b00, C_PRIME};
    localparam logic [SUM_W-1:0] P2 = P1 << 1;
    localparam logic [SUM_W-1:0] P3 = P1 + P2;

    logic [C_CNT_W-1:0] r_count;
    logic [C_CNT_W-1:0] n_count;
    logic [SUM_W-1:0]   w_scaled;
    logic [SUM_W-1:0]   w_add;
    logic [SUM_W-1:0]   w_sum;
    logic [SUM_W-1:0]   w_red;

    // A wildcard triples every filling seen so far and also extends the shorter prefix.
    always_comb begin
        w_scaled = i_ctrl.wild ? (({2'b00, r_count} << 1) + {2'b00, r_count})
                               : {2'b00, r_count};
        w_add    = (i_ctrl.wild || i_ctrl.match) ? {2'b00, i_left} : '0;
        w_sum    = w_scaled + w_add;
        // The sum stays below four times the prime, so one of four offsets brings it back.
        if (w_sum >= P3) begin
            w_red = w_sum - P3;
        end else if (w_sum >= P2) begin
            w_red = w_sum - P2;
        end else if (w_sum >= P1) begin
            w_red = w_sum - P1;
        end else begin
            w_red = w_sum;
        end
    end

    assign o_next = w_red[C_CNT_W-1:0];

    always_comb begin
        n_count = r_count;
        if (i_ctrl.step) begin
            if (i_ctrl.restart) begin
                n_count = {{(C_CNT_W-1){1'b0}}, i_ctrl.origin};
            end else begin
                n_count = o_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= {{(C_CNT_W-1){1'b0}}, i_ctrl.origin};
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

// ===== rtl/core/wildcard_abc_subsequence_counter_core.sv =====
// Top level of the wildcard abc subsequence counter.
//
//  channel   | dir | payload               | word
//  i_sym     | in  | symbol[7:0], last     | one character of the string
//  o_total   | out | total[29:0]           | count modulo 1000000007, once per string
//
// One character word is taken every cycle while i_sym.ready is high; the chain of four cells updates in that cycle.
// The total leaves from the output register in the cycle after the last character is taken.
// i_sym stalls only while a total waits in the output register and o_total.ready is low.
// Synchronous reset returns the chain to the empty-string counts and drops a pending total.
module wildcard_abc_subsequence_counter_core
    import wasc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    wasc_sym_if.sink      i_sym,
    wasc_total_if.source  o_total
);

    t_cell_ctrl         w_ctrl  [C_NUM_CELLS];
    logic [C_CNT_W-1:0] w_count [C_NUM_CELLS];
    logic [C_CNT_W-1:0] w_next  [C_NUM_CELLS];
    logic               w_accept;
    logic               w_wild;
    logic               r_out_valid;
    logic [C_CNT_W-1:0] r_total;

    assign i_sym.ready = !r_out_valid || o_total.ready;
    assign w_accept    = i_sym.valid && i_sym.ready;
    assign w_wild      = (i_sym.symbol == C_WILDCARD);

    // Cell g counts matches of the first g pattern letters; cell 0 only scales.
    for (genvar g = 0; g < C_NUM_CELLS; g++) begin : g_cell
        logic [C_CNT_W-1:0] w_left;

        if (g == 0) begin : g_head
            assign w_ctrl[g].match = 1'b0;
            assign w_left          = '0;
        end else begin : g_body
            assign w_ctrl[g].match = (i_sym.symbol == (C_FIRST_LETTER + 8'(g - 1)));
            assign w_left          = w_count[g-1];
        end

        assign w_ctrl[g].step    = w_accept;
        assign w_ctrl[g].wild    = w_wild;
        assign w_ctrl[g].restart = i_sym.last;
        assign w_ctrl[g].origin  = (g == 0);

        wasc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl[g]),
            .i_left  (w_left),
            .o_count (w_count[g]),
            .o_next  (w_next[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && i_sym.last) begin
            r_out_valid <= 1'b1;
        end else if (o_total.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_sym.last) begin
            r_total <= w_next[C_NUM_CELLS-1];
        end
    end

    assign o_total.valid = r_out_valid;
    assign o_total.total = r_total;

endmodule

// ===== rtl/core/wasc_checker.sv =====
// Port-level checks for the subsequence counter, bound to the top level.
`include "wildcard_abc_subsequence_counter_core_assert.svh"

module wasc_checker
    import wasc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_in_last,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [C_CNT_W-1:0] i_out_total
);

    logic w_in_accept;

    assign w_in_accept = i_in_valid && i_in_ready;

    `WASC_ASSERT_NOW(a_total_reduced, i_clk, i_rst_n, i_out_valid, i_out_total < C_PRIME, "total word not reduced")
    `WASC_ASSERT_NEXT(a_last_gives_total, i_clk, i_rst_n, w_in_accept && i_in_last, i_out_valid, "no total after last word")
    `WASC_ASSERT_NOW(a_total_has_cause, i_clk, i_rst_n, $rose(i_out_valid), $past(w_in_accept && i_in_last), "total word without last word")
    `WASC_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input stalled with empty output")
    `WASC_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_total), "stalled total word changed")

endmodule

bind wildcard_abc_subsequence_counter_core wasc_checker u_wasc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sym.valid),
    .i_in_ready  (i_sym.ready),
    .i_in_last   (i_sym.last),
    .i_out_valid (o_total.valid),
    .i_out_ready (o_total.ready),
    .i_out_total (o_total.total)
);

// ===== test/wildcard_abc_subsequence_counter_core_test.sv =====
// Self-checking testbench for the wildcard abc subsequence counter core.
`timescale 1ns / 1ps

module wildcard_abc_subsequence_counter_core_test;
    import wasc_pkg::*;

    localparam logic [7:0] CH_A = C_FIRST_LETTER;
    localparam logic [7:0] CH_B = C_FIRST_LETTER + 8'd1;
    localparam logic [7:0] CH_C = C_FIRST_LETTER + 8'd2;
    localparam logic [7:0] CH_WILD = C_WILDCARD;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned DRAIN_LIMIT = 10000;
    localparam int unsigned RANDOM_WORDS = 1300;
    localparam int unsigned QUIET_WORDS = 300;
    localparam int unsigned LONG_WORDS = 300;
    localparam int unsigned STALL_CYCLES = 400;
    localparam int unsigned STALL_WORDS = 40;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef logic [7:0] t_char_q [$];

    logic clk;
    logic rst_n;

    wasc_sym_if   sym_ch ();
    wasc_total_if total_ch ();

    wildcard_abc_subsequence_counter_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_sym   (sym_ch.sink),
        .o_total (total_ch.source)
    );

    // Running state of the string being sent, kept alongside the block.
    logic [C_CNT_W-1:0] match_counts [16];
    logic [C_CNT_W-1:0] pow3_window [4];
    logic [C_CNT_W-1:0] pending_totals [$];

    bit          src_idle = 1'b1;
    bit          sink_idle = 1'b1;
    int unsigned sink_hold = 0;
    int unsigned fault_count = 0;
    int unsigned cycle_count = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [C_CNT_W-1:0] add_mod(input logic [C_CNT_W-1:0] a,
                                                   input logic [C_CNT_W-1:0] b);
        logic [C_CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, C_PRIME}) begin
            s = s - {1'b0, C_PRIME};
        end
        return s[C_CNT_W-1:0];
    endfunction

    function automatic logic [C_CNT_W-1:0] mul_mod(input logic [C_CNT_W-1:0] a,
                                                   input logic [C_CNT_W-1:0] b);
        logic [63:0] p;
        p = (64'(a) * 64'(b)) % 64'(C_PRIME);
        return p[C_CNT_W-1:0];
    endfunction

    function automatic void clear_counts();
        foreach (match_counts[i]) match_counts[i] = '0;
        foreach (pow3_window[i]) pow3_window[i] = '0;
        match_counts[0] = C_CNT_W'(1);
        pow3_window[0] = C_CNT_W'(1);
    endfunction

    // Advances the counts by one accepted character and queues the total on the last one.
    function automatic void track_char(input logic [7:0] sym, input logic is_last);
        logic [C_CNT_W-1:0] prev [16];
        logic [C_CNT_W-1:0] sum;
        logic               wild;
        int                 nk;
        wild = (sym == CH_WILD);
        prev = match_counts;
        for (int j = 0; j < 3; j++) begin
            if (wild || sym == C_FIRST_LETTER + j) begin
                for (int k = 0; k < 4; k++) begin
                    nk = wild ? k + 1 : k;
                    if (nk <= 3) begin
                        match_counts[(j + 1) * 4 + nk] =
                            add_mod(match_counts[(j + 1) * 4 + nk], prev[j * 4 + k]);
                    end
                end
            end
        end
        if (wild) begin
            pow3_window[3] = pow3_window[2];
            pow3_window[2] = pow3_window[1];
            pow3_window[1] = pow3_window[0];
            pow3_window[0] = mul_mod(pow3_window[0], C_CNT_W'(3));
        end
        if (is_last) begin
            sum = '0;
            for (int k = 0; k < 4; k++) begin
                sum = add_mod(sum, mul_mod(match_counts[12 + k], pow3_window[k]));
            end
            pending_totals.push_back(sum);
            clear_counts();
        end
    endfunction

    function automatic logic [7:0] pick_char();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 4) return CH_A;
        if (r < 8) return CH_B;
        if (r < 12) return CH_C;
        if (r < 15) return CH_WILD;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic bit is_pattern_char(input logic [7:0] sym);
        return sym == CH_A || sym == CH_B || sym == CH_C || sym == CH_WILD;
    endfunction

    task automatic flag_fault(input string what, input logic [C_CNT_W-1:0] want,
                              input logic [C_CNT_W-1:0] got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
            $display("mismatch at %0t: %s, expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    task automatic send_char(input logic [7:0] sym, input logic is_last);
        if (src_idle && $urandom_range(0, 5) == 0) begin
            sym_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        sym_ch.valid  <= 1'b1;
        sym_ch.symbol <= sym;
        sym_ch.last   <= is_last;
        do @(posedge clk); while (!sym_ch.ready);
        track_char(sym, is_last);
    endtask

    task automatic send_text(input t_char_q chars);
        foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
    endtask

    task automatic test_directed();
        send_text('{CH_A, CH_B, CH_C});
        send_text('{CH_WILD, CH_WILD, CH_WILD, CH_WILD});
        send_text('{CH_A});
        send_text('{CH_C, CH_B, CH_A});
        // Bytes around the letters and the wildcard must match nothing.
        send_text('{8'h00, CH_A, 8'hFF, CH_B, 8'h60, CH_WILD, 8'h64, 8'h3E, CH_C, 8'h40});
        send_text('{CH_WILD, CH_A, CH_B});
    endtask

    // A single string long enough for the table counts to wrap around the prime.
    task automatic test_long_string();
        logic [7:0] sym;
        for (int i = 0; i < LONG_WORDS; i++) begin
            sym = ($urandom_range(0, 7) != 0) ? CH_WILD : pick_char();
            send_char(sym, i == LONG_WORDS - 1);
        end
    endtask

    // Short strings against a long output stall, so a total backs up and input stalls.
    task automatic test_output_stall();
        bit saved_idle;
        saved_idle = src_idle;
        src_idle = 1'b0;
        sink_hold = STALL_CYCLES;
        for (int i = 0; i < STALL_WORDS; i++) begin
            send_char(pick_char(), $urandom_range(0, 2) == 0 || i == STALL_WORDS - 1);
        end
        src_idle = saved_idle;
    endtask

    task automatic test_random(input int unsigned words);
        int unsigned sent;
        int unsigned len;
        bit          heavy;
        logic [7:0]  sym;
        sent = 0;
        while (sent < words) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
            heavy = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++) begin
                sym = (heavy && $urandom_range(0, 1) == 1) ? CH_WILD : pick_char();
                send_char(sym, i == len - 1);
                if (is_pattern_char(sym)) sent++;
            end
        end
    endtask

    // Drives the output ready, either from a requested hold or from random bursts.
    initial begin : total_sink
        int unsigned span;
        forever begin
            if (sink_hold != 0) begin
                total_ch.ready <= 1'b0;
                span = sink_hold;
                sink_hold = 0;
            end else if (sink_idle && $urandom_range(0, 7) == 0) begin
                total_ch.ready <= 1'b0;
                span = $urandom_range(1, 19);
            end else begin
                total_ch.ready <= 1'b1;
                span = 1;
            end
            repeat (span) @(posedge clk);
        end
    end

    // Every total word is matched against the oldest expected total.
    initial begin : total_check
        logic [C_CNT_W-1:0] want;
        forever begin
            @(posedge clk);
            if (rst_n && total_ch.valid && total_ch.ready) begin
                if (pending_totals.size() == 0) begin
                    flag_fault("total with none pending", '0, total_ch.total);
                end else begin
                    want = pending_totals.pop_front();
                    if (total_ch.total !== want) begin
                        flag_fault("total", want, total_ch.total);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : run
        int unsigned drain;
        sym_ch.valid  <= 1'b0;
        sym_ch.symbol <= 8'h00;
        sym_ch.last   <= 1'b0;
        rst_n         <= 1'b0;
        clear_counts();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_long_string();
        test_output_stall();
        test_random(RANDOM_WORDS);
        src_idle = 1'b0;
        sink_idle = 1'b0;
        test_random(QUIET_WORDS);

        sym_ch.valid <= 1'b0;
        drain = 0;
        while (pending_totals.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge clk);
            drain++;
        end
        repeat (4) @(posedge clk);
        if (pending_totals.size() != 0) begin
            $display("%0d expected totals never arrived", pending_totals.size());
        end
        if (fault_count == 0 && pending_totals.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
